@@ rtl/esst_pkg.sv @@
package esst_pkg;

	localparam int CNT_W = 32;
	localparam int DIFF_W = CNT_W + 1;
	localparam int COL_W = 16;
	localparam int STEP_W = 16;
	localparam int CHK_W = 7;

	localparam int unsigned MAX_COLUMN = 65535;
	localparam logic [COL_W-1:0] COL_CAP =
		(MAX_COLUMN > 65535) ? 16'hFFFF : 16'(MAX_COLUMN);
	localparam logic [CHK_W-1:0] GLITCH_FRAMES = 7'd100;
	localparam logic [CNT_W-1:0] GLITCH_LIMIT = 32'd10000;
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd10;

	typedef enum logic {
		REG_STEP_SIZE = 1'b0,
		REG_REVERSE   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_DECIDE,
		ST_DIV,
		ST_UPDATE,
		ST_EMIT
	} state_t;

endpackage

@@ rtl/encoder_scan_step_tracker.sv @@
// Channel  Direction  Signals                         Payload
// s        in         s_tvalid s_tready s_tdata s_tuser  one encoder frame
// m        out        m_tvalid m_tready m_tdata m_tuser  one tracking result
// cfg      in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// A frame with frame_ok low is dropped in its transfer cycle, and a first or
// restart frame goes straight to the emit state. Any other frame passes a
// bit-serial subtractor and a decision state, where a glitch frame is dropped;
// one that moves the column adds a restoring divider and an update state.
// Reset is asynchronous and clears the control and configuration registers only.
// A new frame is taken only when idle; a result held at the output can hold it off.
module encoder_scan_step_tracker
	import esst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // count_a, count_b
	input  logic [1:0]  s_tuser,   // frame_ok, restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // position, column, steps
	output logic [0:0]  m_tuser,   // moved_down
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	state_t state_q;
	state_t state_d;

	logic [STEP_W-1:0] step_q;
	logic              rev_q;
	logic              first_q;
	logic [CHK_W-1:0]  checked_q;
	logic [CNT_W-1:0]  anchor_q;
	logic [COL_W-1:0]  col_q;
	logic [CNT_W-1:0]  pos_q;
	logic              down_q;
	logic [CNT_W-1:0]  res_pos_q;
	logic [COL_W-1:0]  res_col_q;
	logic [COL_W-1:0]  res_steps_q;
	logic              res_down_q;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;
	logic              m_tuser_q;

	logic              in_xfer;
	logic              ser_start;
	logic              ser_done;
	logic [CNT_W-1:0]  ser_ab;
	logic [CNT_W-1:0]  ser_ba;
	logic [DIFF_W-1:0] ser_diff;
	logic [DIFF_W-1:0] ser_ndiff;
	logic              div_start;
	logic              div_done;
	logic [CNT_W-1:0]  div_quo;
	logic [STEP_W-1:0] div_rem;

	logic [STEP_W-1:0] step_eff;
	logic              window;
	logic [CNT_W-1:0]  ab_mag;
	logic              glitch;
	logic              neg;
	logic [CNT_W-1:0]  mag;
	logic              mag_ge;
	logic              move;
	logic [COL_W-1:0]  limit;
	logic              n_over;
	logic [COL_W-1:0]  steps;
	logic              out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			rev_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STEP_SIZE: step_q <= cfg_data;
				REG_REVERSE:   rev_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	esst_serial_sub u_sub (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ser_start),
		.reverse(rev_q),
		.a      (s_tdata[31:0]),
		.b      (s_tdata[63:32]),
		.anchor (anchor_q),
		.done   (ser_done),
		.ab     (ser_ab),
		.ba     (ser_ba),
		.diff   (ser_diff),
		.ndiff  (ser_ndiff)
	);

	esst_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (step_eff),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_comb begin
		step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
		window = (checked_q < GLITCH_FRAMES);
		ab_mag = ser_ab[CNT_W-1] ? ser_ba : ser_ab;
		glitch = window && (ab_mag > GLITCH_LIMIT);
		neg = ser_diff[DIFF_W-1];
		mag = neg ? ser_ndiff[CNT_W-1:0] : ser_diff[CNT_W-1:0];
		mag_ge = (mag[CNT_W-1:STEP_W] != '0) || (mag[STEP_W-1:0] >= step_eff);
		move = mag_ge && (!neg || (col_q != '0));
		limit = down_q ? col_q : (COL_CAP - col_q);
		n_over = (div_quo[CNT_W-1:COL_W] != '0) || (div_quo[COL_W-1:0] > limit);
		steps = n_over ? limit : div_quo[COL_W-1:0];
		out_free = !m_tvalid_q || m_tready;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		ser_start = 1'b0;
		div_start = 1'b0;
		in_xfer = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				in_xfer = s_tvalid;
				if (s_tvalid && s_tuser[0]) begin
					if (first_q || s_tuser[1]) begin
						state_d = ST_EMIT;
					end else begin
						ser_start = 1'b1;
						state_d = ST_SUB;
					end
				end
			end
			ST_SUB: begin
				if (ser_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (glitch) begin
					state_d = ST_IDLE;
				end else if (move) begin
					div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			checked_q <= '0;
			anchor_q <= '0;
			col_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_xfer && s_tuser[0] && (first_q || s_tuser[1])) begin
				first_q <= 1'b0;
			end
			if (state_q == ST_DECIDE && !glitch && window) begin
				checked_q <= checked_q + CHK_W'(1);
			end
			if (state_q == ST_UPDATE) begin
				col_q <= down_q ? (col_q - steps) : (col_q + steps);
				anchor_q <= down_q ? (pos_q + CNT_W'(div_rem)) : (pos_q - CNT_W'(div_rem));
			end
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_tuser[0] && (first_q || s_tuser[1])) begin
			res_pos_q <= '0;
			res_col_q <= col_q;
			res_steps_q <= '0;
			res_down_q <= 1'b0;
		end
		if (state_q == ST_DECIDE) begin
			pos_q <= rev_q ? ser_ba : ser_ab;
			down_q <= neg;
			res_pos_q <= rev_q ? ser_ba : ser_ab;
			res_col_q <= col_q;
			res_steps_q <= '0;
			res_down_q <= 1'b0;
		end
		if (state_q == ST_UPDATE) begin
			res_col_q <= down_q ? (col_q - steps) : (col_q + steps);
			res_steps_q <= steps;
			res_down_q <= down_q;
		end
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= {res_steps_q, res_col_q, res_pos_q};
			m_tuser_q <= res_down_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

`ifndef SYNTHESIS
	a_col_cap: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_CAP)
		else $error("scan column above its limit");

	a_checked_window: assert property (@(posedge clk) disable iff (!arst_n)
		checked_q <= GLITCH_FRAMES)
		else $error("checked frame count ran past the glitch window");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_down_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && down_q) |=> res_steps_q != '0)
		else $error("downward result without a step");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !out_free) |=> state_q == ST_EMIT)
		else $error("result left before the output register was free");
`endif

endmodule

@@ rtl/esst_serial_sub.sv @@
module esst_serial_sub
	import esst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              reverse,
	input  logic [CNT_W-1:0]  a,
	input  logic [CNT_W-1:0]  b,
	input  logic [CNT_W-1:0]  anchor,
	output logic              done,
	output logic [CNT_W-1:0]  ab,
	output logic [CNT_W-1:0]  ba,
	output logic [DIFF_W-1:0] diff,
	output logic [DIFF_W-1:0] ndiff
);

	localparam logic [5:0] LAST_BIT = 6'(DIFF_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [CNT_W-1:0]  a_q;
	logic [CNT_W-1:0]  b_q;
	logic [CNT_W-1:0]  anc_q;
	logic              c_ab_q;
	logic              c_ba_q;
	logic              c_d_q;
	logic              c_n_q;
	logic              pmsb_q;
	logic [CNT_W-1:0]  ab_q;
	logic [CNT_W-1:0]  ba_q;
	logic [DIFF_W-1:0] diff_q;
	logic [DIFF_W-1:0] ndiff_q;

	logic abit;
	logic bbit;
	logic nbit;
	logic ab_s;
	logic ba_s;
	logic pbit;
	logic d_s;
	logic n_s;
	logic last;

	// Each cycle handles one bit, least significant first; the carries
	// start at one because every unit subtracts.
	always_comb begin
		abit = a_q[0];
		bbit = b_q[0];
		nbit = anc_q[0];
		last = (cnt_q == LAST_BIT);
		ab_s = abit ^ ~bbit ^ c_ab_q;
		ba_s = bbit ^ ~abit ^ c_ba_q;
		pbit = last ? pmsb_q : (reverse ? ba_s : ab_s);
		d_s = pbit ^ ~nbit ^ c_d_q;
		n_s = nbit ^ ~pbit ^ c_n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			anc_q <= anchor;
			c_ab_q <= 1'b1;
			c_ba_q <= 1'b1;
			c_d_q <= 1'b1;
			c_n_q <= 1'b1;
		end else if (busy_q) begin
			a_q <= {1'b0, a_q[CNT_W-1:1]};
			b_q <= {1'b0, b_q[CNT_W-1:1]};
			anc_q <= {anc_q[CNT_W-1], anc_q[CNT_W-1:1]};
			c_ab_q <= (abit & ~bbit) | (abit & c_ab_q) | (~bbit & c_ab_q);
			c_ba_q <= (bbit & ~abit) | (bbit & c_ba_q) | (~abit & c_ba_q);
			c_d_q <= (pbit & ~nbit) | (pbit & c_d_q) | (~nbit & c_d_q);
			c_n_q <= (nbit & ~pbit) | (nbit & c_n_q) | (~pbit & c_n_q);
			pmsb_q <= pbit;
			diff_q <= {d_s, diff_q[DIFF_W-1:1]};
			ndiff_q <= {n_s, ndiff_q[DIFF_W-1:1]};
			if (!last) begin
				ab_q <= {ab_s, ab_q[CNT_W-1:1]};
				ba_q <= {ba_s, ba_q[CNT_W-1:1]};
			end
		end
	end

	assign done = done_q;
	assign ab = ab_q;
	assign ba = ba_q;
	assign diff = diff_q;
	assign ndiff = ndiff_q;

endmodule

@@ rtl/esst_divider.sv @@
module esst_divider
	import esst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  dividend,
	input  logic [STEP_W-1:0] divisor,
	output logic              done,
	output logic [CNT_W-1:0]  quotient,
	output logic [STEP_W-1:0] remainder
);

	localparam logic [4:0] LAST_BIT = 5'(CNT_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [STEP_W-1:0] dsr_q;
	logic [STEP_W-1:0] rem_q;
	logic [CNT_W-1:0]  quo_q;

	logic [STEP_W:0] trial;
	logic [STEP_W:0] less;
	logic            fits;

	// Restoring division, one quotient bit per cycle. The quotient bits
	// shift in behind the dividend bits as those move out.
	always_comb begin
		trial = {rem_q, quo_q[CNT_W-1]};
		fits = (trial >= {1'b0, dsr_q});
		less = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? less[STEP_W-1:0] : trial[STEP_W-1:0];
			quo_q <= {quo_q[CNT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule
